[hdl/spq_pkg.sv]
// Types and codes shared by the severity priority queue cell and core.
// No dependencies.
package spq_pkg;

   localparam int TAG_W  = 16;
   localparam int SEV_W  = 3;
   localparam int OCC_W  = 7;
   localparam int STAT_W = 2;

   localparam logic [SEV_W-1:0] SEV_MIN = 3'd1;
   localparam logic [SEV_W-1:0] SEV_MAX = 3'd5;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic             opcode;
      logic [TAG_W-1:0] item_tag;
      logic [SEV_W-1:0] severity;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [TAG_W-1:0]  out_tag;
      logic [SEV_W-1:0]  out_severity;
      logic [OCC_W-1:0]  occupancy;
   } rsp_type;

   // One stored entry.
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [SEV_W-1:0] sev;
   } entry_type;

   // Broadcast from the core to every cell.
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type item;
   } cell_ctrl_type;

   function automatic logic [SEV_W-1:0] sev_clamp(input logic [SEV_W-1:0] sev);
      logic [SEV_W-1:0] res;
      res = sev;
      if (sev < SEV_MIN) begin
         res = SEV_MIN;
      end else if (sev > SEV_MAX) begin
         res = SEV_MAX;
      end
      return res;
   endfunction

endpackage

[hdl/severity_priority_queue_core.sv]
// Top level of the severity priority queue: a row of spq_cell slots plus
// the item counter and the registered response. Depends on spq_pkg, spq_cell.
//
//  channel   | ports                       | handshake
//  ----------+-----------------------------+---------------------------------
//  request   | start, busy, req_data       | taken when start & !busy
//  response  | rsp_valid, rsp_data         | one-cycle strobe, cannot stall
//
// One request per cycle: every cell compares its severity against the new
// item in parallel and shifts or loads in the same edge, so busy stays low.
// The response for a request taken at edge N is on rsp_* for the cycle after
// edge N. Reset clears the item counter and the response strobe only; slot
// contents are never read beyond the counter, so they need no clearing.
module severity_priority_queue_core
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   cell_ctrl_type    ctrl;
   logic             accept;
   logic             full, empty;

   logic      cell_ge   [QUEUE_DEPTH];
   entry_type cell_data [QUEUE_DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);

   // Broadcast the operation; a full insert or empty remove does nothing.
   always_comb begin
      ctrl.insert   = accept && (req_data.opcode == OP_INSERT) && !full;
      ctrl.remove   = accept && (req_data.opcode == OP_REMOVE) && !empty;
      ctrl.item.tag = req_data.item_tag;
      ctrl.item.sev = sev_clamp(req_data.severity);
   end

   // The slot row. Slot 0 has no left neighbor: it loads the new item
   // whenever it is displaced. The last slot keeps itself on a remove.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic      left_ge;
      entry_type left_data;
      entry_type right_data;

      if (i == 0) begin : g_head
         assign left_ge   = 1'b0;
         assign left_data = ctrl.item;
      end else begin : g_body
         assign left_ge   = cell_ge[i-1];
         assign left_data = cell_data[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_data = cell_data[i];
      end else begin : g_mid
         assign right_data = cell_data[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (CNT_W'(i) < count_ff),
         .left_ge    (left_ge),
         .left_data  (left_data),
         .right_data (right_data),
         .ge         (cell_ge[i]),
         .data       (cell_data[i])
      );
   end

   // Counter and response.
   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.remove) begin
         count_in = count_ff - CNT_W'(1);
      end

      rsp_valid_in        = accept;
      rsp_in.status       = STATUS_OK;
      rsp_in.out_tag      = '0;
      rsp_in.out_severity = '0;
      if (req_data.opcode == OP_INSERT) begin
         if (full) begin
            rsp_in.status = STATUS_FULL;
         end
      end else if (empty) begin
         rsp_in.status = STATUS_EMPTY;
      end else begin
         rsp_in.out_tag      = cell_data[0].tag;
         rsp_in.out_severity = cell_data[0].sev;
      end
      // occupancy is reported modulo 2^OCC_W
      rsp_in.occupancy = OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hdl/spq_cell.sv]
// One slot of the sorted shift-register queue.
// Depends on spq_pkg.
module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  logic          left_ge,
   input  entry_type     left_data,
   input  entry_type     right_data,
   output logic          ge,
   output entry_type     data
);

   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [SEV_W-1:0] sev_ff, sev_in;

   // stays put on insert when it holds an equal or more severe item
   assign ge   = occupied && (sev_ff >= ctrl.item.sev);
   assign data = '{tag: tag_ff, sev: sev_ff};

   // remove shifts left; first displaced takes new item, rest shift right
   always_comb begin
      tag_in = tag_ff;
      sev_in = sev_ff;
      if (ctrl.remove) begin
         tag_in = right_data.tag;
         sev_in = right_data.sev;
      end else if (ctrl.insert && !ge) begin
         if (left_ge) begin
            tag_in = ctrl.item.tag;
            sev_in = ctrl.item.sev;
         end else begin
            tag_in = left_data.tag;
            sev_in = left_data.sev;
         end
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      sev_ff <= sev_in;
   end

endmodule

[bench/tb_severity_priority_queue_core.sv]
// Self-checking bench for severity_priority_queue_core: directed and random
// insert/remove requests checked against an in-bench model of the sorted queue.
// Depends on spq_pkg and the core RTL.
module tb_severity_priority_queue_core
   import spq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH  = 64;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ITEMS = 400;
   localparam int TAIL_ITEMS   = 80;      // closing stretch, sender never idles
   localparam int CYCLE_LIMIT  = 200000;  // watchdog bound, far above what the run of requests needs
   localparam int MAX_REPORTS  = 50;      // cap on detailed mismatch lines

   // Tracks what the queue should hold and the response each request must produce.
   class spq_tracker;
      logic [TAG_W-1:0] held_tag [QUEUE_DEPTH];
      logic [SEV_W-1:0] held_sev [QUEUE_DEPTH];
      int      held_count;
      rsp_type awaited [$];
      int      errors;
      int      n_insert, n_remove, n_full, n_empty, peak;

      function void flag(string field, logic [31:0] want, logic [31:0] got);
         errors++;
         if (errors <= MAX_REPORTS) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         end
      endfunction

      // Apply one accepted request to the shadow queue and queue its response.
      function void note_request(req_type r);
         rsp_type          want;
         logic [SEV_W-1:0] sev;
         int               pos;
         int               i;
         want = '0;
         if (r.opcode == OP_INSERT) begin
            n_insert++;
            if (held_count >= QUEUE_DEPTH) begin
               want.status = STATUS_FULL;
               n_full++;
            end else begin
               sev = r.severity;
               if (sev < SEV_MIN) begin
                  sev = SEV_MIN;
               end else if (sev > SEV_MAX) begin
                  sev = SEV_MAX;
               end
               // goes behind everything of equal or higher severity
               pos = 0;
               while (pos < held_count && held_sev[pos] >= sev) pos++;
               for (i = held_count; i > pos; i--) begin
                  held_tag[i] = held_tag[i-1];
                  held_sev[i] = held_sev[i-1];
               end
               held_tag[pos] = r.item_tag;
               held_sev[pos] = sev;
               held_count++;
               if (held_count > peak) peak = held_count;
            end
         end else begin
            n_remove++;
            if (held_count == 0) begin
               want.status = STATUS_EMPTY;
               n_empty++;
            end else begin
               want.out_tag      = held_tag[0];
               want.out_severity = held_sev[0];
               for (i = 1; i < held_count; i++) begin
                  held_tag[i-1] = held_tag[i];
                  held_sev[i-1] = held_sev[i];
               end
               held_count--;
            end
         end
         want.occupancy = OCC_W'(held_count);
         awaited.push_back(want);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            errors++;
            $error("response strobe with no request outstanding: 0x%0h", got);
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status) begin
            flag("status", 32'(want.status), 32'(got.status));
         end
         if (got.out_tag !== want.out_tag) begin
            flag("out_tag", 32'(want.out_tag), 32'(got.out_tag));
         end
         if (got.out_severity !== want.out_severity) begin
            flag("out_severity", 32'(want.out_severity), 32'(got.out_severity));
         end
         if (got.occupancy !== want.occupancy) begin
            flag("occupancy", 32'(want.occupancy), 32'(got.occupancy));
         end
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   spq_tracker tracker = new;
   int         cycle_count = 0;

   severity_priority_queue_core #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Monitor: everything is sampled at the rising edge, before the edge's
   // updates land. A response at this edge belongs to a request taken at an
   // earlier edge, so checking before noting keeps the FIFO order intact.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) tracker.check_response(rsp_data);
         if (start && !busy) tracker.note_request(req_data);
      end
   end

   // Watchdog: a hung handshake or a missing response ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d responses still awaited",
                cycle_count, tracker.outstanding());
         $display("severity_priority_queue_core verification failed");
         $finish;
      end
   end

   function automatic req_type make_req(opcode_type op, logic [TAG_W-1:0] tag,
                                        logic [SEV_W-1:0] sev);
      req_type r;
      r.opcode   = op;
      r.item_tag = tag;
      r.severity = sev;
      return r;
   endfunction

   // Random request; insert_pct sets the insert/remove mix. About one insert
   // in ten carries an out-of-range severity (0, 6 or 7) to hit the clamping.
   function automatic req_type random_request(int insert_pct);
      logic [SEV_W-1:0] sev;
      opcode_type       op;
      op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(2))
            0:       sev = 3'd0;
            1:       sev = 3'd6;
            default: sev = 3'd7;
         endcase
      end else begin
         sev = SEV_W'($urandom_range(5, 1));
      end
      return make_req(op, TAG_W'($urandom), sev);
   endfunction

   // Present one request from the falling edge and hold it until taken.
   // start stays high between back-to-back requests.
   task automatic send_request(req_type r);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic pause_requests(int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold off the sender until every response has come back.
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int seg;
      int seg_len;
      int bias;
      bit idle_on;

      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // remove from the empty queue; tag and severity must be ignored
      send_request(make_req(OP_REMOVE, 16'hFFFF, 3'd7));
      // severity clamping at both ends, tag extremes
      send_request(make_req(OP_INSERT, 16'h0000, 3'd0));   // stored as 1
      send_request(make_req(OP_INSERT, 16'hFFFF, 3'd7));   // stored as 5
      send_request(make_req(OP_INSERT, 16'h8000, 3'd6));   // 5, queued behind FFFF
      // same severity leaves in arrival order
      send_request(make_req(OP_INSERT, 16'h1234, 3'd3));
      send_request(make_req(OP_INSERT, 16'h5678, 3'd3));
      send_request(make_req(OP_INSERT, 16'h00FF, 3'd5));
      pause_requests(3);
      send_request(make_req(OP_INSERT, 16'h0001, 3'd1));
      send_request(make_req(OP_INSERT, 16'hAAAA, 3'd2));
      send_request(make_req(OP_INSERT, 16'h5555, 3'd4));
      // drain all nine, then one more into the empty queue
      repeat (10) send_request(make_req(OP_REMOVE, 16'h0000, 3'd0));
      // insert then immediate remove, back to back
      send_request(make_req(OP_INSERT, 16'h0F0F, 3'd2));
      send_request(make_req(OP_REMOVE, 16'h7FFF, 3'd5));
      wait_drained();

      // ---- random part ----
      // Segments cycle through fill-heavy, drain-heavy, balanced and random
      // mixes so the queue runs into both the full and the empty wall. The
      // first two are long enough to get there for sure.
      sent = 0;
      seg  = 0;
      while (sent < RANDOM_ITEMS - TAIL_ITEMS) begin
         case (seg % 4)
            0:       bias = 90;
            1:       bias = 12;
            2:       bias = 50;
            default: bias = $urandom_range(80, 20);
         endcase
         seg_len = (seg < 2) ? 120 : $urandom_range(90, 40);
         idle_on = (seg % 3 != 2);     // every third segment runs flat out
         repeat (seg_len) begin
            send_request(random_request(bias));
            if (idle_on && $urandom_range(3) == 0) pause_requests($urandom_range(12, 1));
         end
         sent += seg_len;
         seg++;
         // once, let the pipe run dry before carrying on
         if (seg == 1) wait_drained();
      end

      // closing stretch: balanced mix, no sender gaps
      repeat (TAIL_ITEMS) send_request(random_request(50));

      wait_drained();
      repeat (4) @(posedge clock);
      if (tracker.outstanding() != 0) begin
         tracker.errors += tracker.outstanding();
         $error("%0d responses never arrived", tracker.outstanding());
      end

      $display("run: %0d inserts (%0d refused full), %0d removes (%0d on empty)",
               tracker.n_insert, tracker.n_full, tracker.n_remove, tracker.n_empty);
      $display("run: peak occupancy %0d of %0d, %0d check failures",
               tracker.peak, QUEUE_DEPTH, tracker.errors);
      if (tracker.errors == 0) begin
         $display("severity_priority_queue_core verification clean");
      end else begin
         $display("severity_priority_queue_core verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/severity_priority_queue_core.sv
bench/tb_severity_priority_queue_core.sv
